### hw/rtl/gblur_pkg.sv
// Shared types and constants for the RGB Gaussian blur block.
// Used by the lane, merge, top level and checker files.
// No dependencies.
package gblur_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_KERNEL_DEF  = 7;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    // Configuration port shape
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_W3     = 3'd6;

    // Register reset values
    localparam logic [2:0]  KSIZE_RST  = 3'd3;
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [11:0] HEIGHT_RST = 12'd480;
    localparam logic [16:0] W0_RST     = 17'd32768;
    localparam logic [16:0] W1_RST     = 17'd16384;
    localparam logic [16:0] W2_RST     = 17'd0;
    localparam logic [16:0] W3_RST     = 17'd0;

    // Row and column arithmetic width
    localparam int ROW_W = 13;
    // Packed pixel: three 8-bit channels
    localparam int PIX_W = 24;
    localparam int N_LANES = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CHECK,
        ST_DUP,
        ST_HSUM,
        ST_LOAD,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // Per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic v_clr;
        logic v_en;
        logic load_all;
        logic shift_new;
        logic shift_dup;
        logic h_clr;
        logic h_en;
    } lane_ctrl_t;

endpackage

### hw/rtl/gblur_lane.sv
// One color-channel lane: vertical tap sum, column-sum window, horizontal
// tap sum with saturation. Depends on gblur_pkg.
module gblur_lane #(
    parameter int MAX_KERNEL = gblur_pkg::MAX_KERNEL_DEF,
    parameter int TAP_W      = gblur_pkg::WEIGHT_BITS_DEF + 1,
    parameter int V_W        = TAP_W + 8 + $clog2(MAX_KERNEL),
    parameter int ACC_W      = TAP_W + V_W + 1,
    parameter int SAT_SHIFT  = 2 * gblur_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          clk,
    input  gblur_pkg::lane_ctrl_t         ctrl,
    input  logic [7:0]                    pix_byte,
    input  logic [TAP_W-1:0]              v_tap,
    input  logic [TAP_W-1:0]              h_tap,
    input  logic [$clog2(MAX_KERNEL)-1:0] h_idx,
    output logic [7:0]                    result
);
    import gblur_pkg::*;

    localparam logic [ACC_W-1:0] CAP = ACC_W'(1) << (SAT_SHIFT + 8);

    logic [V_W-1:0]   v_acc_reg;
    logic [V_W-1:0]   vwin_reg [MAX_KERNEL];
    logic [ACC_W-1:0] h_acc_reg;
    logic [V_W-1:0]   v_prod;
    logic [ACC_W-1:0] h_prod;
    logic [ACC_W-1:0] h_sum;

    assign v_prod = V_W'(v_tap) * V_W'(pix_byte);
    assign h_prod = ACC_W'(h_tap) * ACC_W'(vwin_reg[h_idx]);
    assign h_sum  = h_acc_reg + h_prod;

    always_ff @(posedge clk)
    begin
        if (ctrl.v_clr)
        begin
            v_acc_reg <= '0;
        end
        else if (ctrl.v_en)
        begin
            v_acc_reg <= v_acc_reg + v_prod;
        end
    end

    // Column-sum window: newest column at the top index
    always_ff @(posedge clk)
    begin
        if (ctrl.load_all)
        begin
            for (int j = 0; j < MAX_KERNEL; j++)
            begin
                vwin_reg[j] <= v_acc_reg;
            end
        end
        else if (ctrl.shift_new || ctrl.shift_dup)
        begin
            for (int j = 0; j < MAX_KERNEL - 1; j++)
            begin
                vwin_reg[j] <= vwin_reg[j+1];
            end
            if (ctrl.shift_new)
            begin
                vwin_reg[MAX_KERNEL-1] <= v_acc_reg;
            end
        end
    end

    // Clamp the running sum at the cap after every column
    always_ff @(posedge clk)
    begin
        if (ctrl.h_clr)
        begin
            h_acc_reg <= '0;
        end
        else if (ctrl.h_en)
        begin
            h_acc_reg <= (h_sum > CAP) ? CAP : h_sum;
        end
    end

    assign result = (|h_acc_reg[ACC_W-1:SAT_SHIFT+8]) ? 8'hFF
                                                       : h_acc_reg[SAT_SHIFT+7:SAT_SHIFT];

endmodule

### hw/rtl/gblur_merge.sv
// Output register: joins the three lane results and the item flags into
// one result item and holds it until taken. Depends on gblur_pkg.
module gblur_merge (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic [gblur_pkg::N_LANES-1:0][7:0]    lane_res,
    input  logic                                  last,
    input  logic                                  fend,
    input  logic                                  res_stall,
    output logic                                  res_valid,
    output logic [7:0]                            blur0,
    output logic [7:0]                            blur1,
    output logic [7:0]                            blur2,
    output logic                                  run_last,
    output logic                                  frame_end
);
    import gblur_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;
    logic [7:0] b2_reg;
    logic       last_reg;
    logic       fend_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b0_reg   <= lane_res[0];
            b1_reg   <= lane_res[1];
            b2_reg   <= lane_res[2];
            last_reg <= last;
            fend_reg <= fend;
        end
    end

    assign res_valid = valid_reg;
    assign blur0     = b0_reg;
    assign blur1     = b1_reg;
    assign blur2     = b2_reg;
    assign run_last  = last_reg;
    assign frame_end = fend_reg;

endmodule

### hw/rtl/gaussian_blur_rgb_replicate.sv
// Top level of the streaming RGB Gaussian blur with replicated edges.
// Holds configuration, the line store, the item sequencer and the lanes.
// Depends on gblur_pkg, gblur_lane and gblur_merge.
//
// Usage:
//   Pixel items (mode 0) arrive in raster order on pix_valid/pix_stall with
//   chan0..chan2. Flush items (mode 1) drain the last rows after the frame's
//   final pixel, image_width ticks per row; a flush before that is dropped.
//   Results leave on res_valid/res_stall as blur0..blur2 with run_last on
//   the last result of an item and frame_end on the frame's final pixel.
//   Configuration is written over cfg_valid/cfg_ready (always ready) with
//   cfg_index and cfg_data while the block is idle.
// Timing:
//   One item is worked at a time; pix_stall stays high while it runs, and
//   the input reopens only after the item's last result has been taken.
//   Each further result of a row end run repeats the horizontal sum. The
//   line store has one read port, so the k column reads are issued one by
//   one, and each result is a k-step horizontal sum in the shared
//   multiplier of each lane. An item with no result (priming) still holds
//   pix_stall while it runs.
// Reset and stall:
//   Reset clears position counters and loads default registers; the line
//   store is not cleared, since every entry is written before it is read.
//   A stalled result holds its payload, and no new item is taken until it
//   is delivered.
module gaussian_blur_rgb_replicate #(
    parameter int MAX_KERNEL  = gblur_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH   = gblur_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = gblur_pkg::WEIGHT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gblur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gblur_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic                             mode,
    input  logic [7:0]                       chan0,
    input  logic [7:0]                       chan1,
    input  logic [7:0]                       chan2,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [7:0]                       blur0,
    output logic [7:0]                       blur1,
    output logic [7:0]                       blur2,
    output logic                             run_last,
    output logic                             frame_end
);
    import gblur_pkg::*;

    localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
    localparam int RING     = MAX_KERNEL - 1;
    localparam int TAP_W    = WEIGHT_BITS + 1;
    localparam int V_W      = TAP_W + 8 + $clog2(MAX_KERNEL);
    localparam int ACC_W    = TAP_W + V_W + 1;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int SW       = $clog2(RING);
    localparam int DEPTH    = RING * MAX_WIDTH;
    localparam int AW       = $clog2(DEPTH);
    localparam int KC       = $clog2(MAX_KERNEL + 1);
    localparam int KI       = $clog2(MAX_KERNEL);

    // ---------------- configuration registers ----------------
    logic [2:0]            ksize_reg;
    logic [10:0]           width_reg;
    logic [11:0]           height_reg;
    logic [CFG_DATA_W-1:0] weight_reg [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksize_reg     <= KSIZE_RST;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            weight_reg[0] <= W0_RST;
            weight_reg[1] <= W1_RST;
            weight_reg[2] <= W2_RST;
            weight_reg[3] <= W3_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KSIZE:  ksize_reg     <= cfg_data[2:0];
                REG_WIDTH:  width_reg     <= cfg_data[10:0];
                REG_HEIGHT: height_reg    <= cfg_data[11:0];
                REG_W0:     weight_reg[0] <= cfg_data;
                REG_W1:     weight_reg[1] <= cfg_data;
                REG_W2:     weight_reg[2] <= cfg_data;
                REG_W3:     weight_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ---------------- derived frame geometry ----------------
    logic [2:0]       r_raw;
    logic [ROW_W-1:0] rad13;
    logic [ROW_W-1:0] two_r13;
    logic [KC-1:0]    rad;
    logic [KC-1:0]    two_r;
    logic [KC-1:0]    k_len;
    logic [ROW_W-1:0] w13;
    logic [ROW_W-1:0] wm1;
    logic [ROW_W-1:0] h13;
    logic [ROW_W-1:0] hm1;
    logic [TAP_W-1:0] tap_arr [4];

    always_comb
    begin
        r_raw   = (ksize_reg == 3'd0) ? 3'd0 : 3'((ksize_reg - 3'd1) >> 1);
        rad13   = (ROW_W'(r_raw) > ROW_W'(HALF_MAX)) ? ROW_W'(HALF_MAX) : ROW_W'(r_raw);
        two_r13 = rad13 << 1;
        rad     = KC'(rad13);
        two_r   = KC'(two_r13);
        k_len   = two_r + KC'(1);
        if (width_reg == 11'd0)
        begin
            w13 = ROW_W'(1);
        end
        else if (ROW_W'(width_reg) > ROW_W'(MAX_WIDTH))
        begin
            w13 = ROW_W'(MAX_WIDTH);
        end
        else
        begin
            w13 = ROW_W'(width_reg);
        end
        wm1 = w13 - ROW_W'(1);
        h13 = (height_reg == 12'd0) ? ROW_W'(1) : ROW_W'(height_reg);
        hm1 = h13 - ROW_W'(1);
        for (int i = 0; i < 4; i++)
        begin
            tap_arr[i] = TAP_W'(weight_reg[i]);
        end
    end

    // ---------------- sequencer state ----------------
    state_t           state_reg, state_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [ROW_W-1:0] ir_reg, ir_next;
    logic [CW-1:0]    ic_reg, ic_next;
    logic             drain_reg, drain_next;
    logic [ROW_W-1:0] vr_reg, vr_next;
    logic [SW-1:0]    vslot_reg, vslot_next;
    logic [KC-1:0]    cnt_reg, cnt_next;
    logic [KC-1:0]    s_reg, s_next;
    logic             flag_reg, flag_next;

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] rdata_reg;
    logic [PIX_W-1:0] line_mem [DEPTH];

    lane_ctrl_t       ctrl;
    logic             mem_rd;
    logic             mem_wr;
    logic             out_load;
    logic             pix_take;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] col_pix;
    logic [TAP_W-1:0] v_tap;
    logic [TAP_W-1:0] h_tap;
    logic [KI-1:0]    h_idx;
    logic [KC-1:0]    tpos;
    logic [KC-1:0]    vd;
    logic [KC-1:0]    hd;

    // accept-time position, after a stale position has been restarted
    logic             stale;
    logic [ROW_W-1:0] irow;
    logic [CW-1:0]    icol_raw;
    logic [ROW_W-1:0] ic13;
    logic [SW-1:0]    slot0;
    logic [SW:0]      back_sum;
    logic             drain;
    logic             rowend;
    logic [KC-1:0]    runs;
    logic             out_ok;
    logic             last_s;
    logic             fend;

    assign pix_stall = (state_reg != ST_IDLE);
    assign pix_take  = pix_valid && !pix_stall;

    always_comb
    begin
        stale    = in_row_reg >= (h13 + rad13);
        irow     = stale ? '0 : in_row_reg;
        icol_raw = stale ? '0 : in_col_reg;
        slot0    = stale ? '0 : slot_reg;
        ic13     = (ROW_W'(icol_raw) >= wm1) ? wm1 : ROW_W'(icol_raw);
        drain    = irow >= h13;
        // slot of row irow-2r, 2r slots back around the ring
        back_sum = (SW+1)'(slot0) + (SW+1)'(RING) - (SW+1)'(two_r);
        if (back_sum >= (SW+1)'(RING))
        begin
            back_sum = back_sum - (SW+1)'(RING);
        end
        rowend = (ROW_W'(ic_reg) == wm1);
        runs   = rowend ? rad : '0;
        out_ok = (ir_reg >= rad13) && (ROW_W'(ic_reg) + ROW_W'(s_reg) >= rad13);
        last_s = (s_reg == runs);
        fend   = rowend && (ir_reg == hm1 + rad13);
    end

    // tap lookup: vertical uses the capture index, horizontal the column index
    always_comb
    begin
        tpos  = cnt_reg - KC'(1);
        vd    = (tpos > rad) ? (tpos - rad) : (rad - tpos);
        hd    = (cnt_reg > rad) ? (cnt_reg - rad) : (rad - cnt_reg);
        v_tap = (ROW_W'(vd) < ROW_W'(4)) ? tap_arr[vd[1:0]] : '0;
        h_tap = (ROW_W'(hd) < ROW_W'(4)) ? tap_arr[hd[1:0]] : '0;
        h_idx = KI'(ROW_W'(MAX_KERNEL - 1) - two_r13 + ROW_W'(cnt_reg));
    end

    assign rd_addr = AW'(vslot_reg) * AW'(MAX_WIDTH) + AW'(ic_reg);
    assign wr_addr = AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(ic_reg);
    assign col_pix = flag_reg ? pix_reg : rdata_reg;

    always_comb
    begin
        state_next  = state_reg;
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        slot_next   = slot_reg;
        ir_next     = ir_reg;
        ic_next     = ic_reg;
        drain_next  = drain_reg;
        vr_next     = vr_reg;
        vslot_next  = vslot_reg;
        cnt_next    = cnt_reg;
        s_next      = s_reg;
        flag_next   = flag_reg;
        ctrl        = '0;
        mem_rd      = 1'b0;
        mem_wr      = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid)
                begin
                    // stale restart holds even for a dropped flush
                    in_row_next = irow;
                    in_col_next = icol_raw;
                    slot_next   = slot0;
                    ir_next     = irow;
                    ic_next     = CW'(ic13);
                    drain_next  = drain;
                    if (!(mode && !drain))
                    begin
                        state_next = ST_READ;
                        cnt_next   = '0;
                        if (irow < two_r13)
                        begin
                            vr_next    = '0;
                            vslot_next = '0;
                        end
                        else
                        begin
                            vr_next    = irow - two_r13;
                            vslot_next = SW'(back_sum);
                        end
                    end
                end
            end

            ST_READ:
            begin
                // issue reads for rows of the column, capture in the cycle after
                if (cnt_reg != k_len)
                begin
                    mem_rd    = 1'b1;
                    flag_next = (vr_reg == ir_reg);
                    if ((ir_reg + ROW_W'(cnt_reg) + ROW_W'(1) > two_r13) && (vr_reg < hm1))
                    begin
                        vr_next    = vr_reg + ROW_W'(1);
                        vslot_next = (vslot_reg == SW'(RING - 1)) ? '0 : vslot_reg + SW'(1);
                    end
                end
                ctrl.v_clr = (cnt_reg == '0);
                ctrl.v_en  = (cnt_reg != '0);
                if (cnt_reg == k_len)
                begin
                    state_next = ST_UPDATE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + KC'(1);
                end
            end

            ST_UPDATE:
            begin
                ctrl.load_all  = (ic_reg == '0);
                ctrl.shift_new = (ic_reg != '0);
                mem_wr         = !drain_reg;
                s_next         = '0;
                state_next     = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (out_ok)
                begin
                    ctrl.h_clr = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_HSUM;
                end
                else if (last_s)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    s_next     = s_reg + KC'(1);
                    state_next = ST_DUP;
                end
            end

            ST_DUP:
            begin
                // replicate the right edge column
                ctrl.shift_dup = 1'b1;
                state_next     = ST_CHECK;
            end

            ST_HSUM:
            begin
                ctrl.h_en = 1'b1;
                if (cnt_reg == two_r)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + KC'(1);
                end
            end

            ST_LOAD:
            begin
                out_load   = 1'b1;
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (res_valid && !res_stall)
                begin
                    if (last_s)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        s_next     = s_reg + KC'(1);
                        state_next = ST_DUP;
                    end
                end
            end

            ST_FINISH:
            begin
                if (fend)
                begin
                    in_row_next = '0;
                    in_col_next = '0;
                    slot_next   = '0;
                end
                else if (rowend)
                begin
                    in_col_next = '0;
                    in_row_next = ir_reg + ROW_W'(1);
                    slot_next   = (slot_reg == SW'(RING - 1)) ? '0 : slot_reg + SW'(1);
                end
                else
                begin
                    in_col_next = ic_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            in_row_reg <= '0;
            in_col_reg <= '0;
            slot_reg   <= '0;
            ir_reg     <= '0;
            ic_reg     <= '0;
            drain_reg  <= 1'b0;
            vr_reg     <= '0;
            vslot_reg  <= '0;
            cnt_reg    <= '0;
            s_reg      <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            slot_reg   <= slot_next;
            ir_reg     <= ir_next;
            ic_reg     <= ic_next;
            drain_reg  <= drain_next;
            vr_reg     <= vr_next;
            vslot_reg  <= vslot_next;
            cnt_reg    <= cnt_next;
            s_reg      <= s_next;
            flag_reg   <= flag_next;
        end
    end

    // Hold the accepted pixel for the whole item
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            pix_reg <= {chan2, chan1, chan0};
        end
    end

    // Line store: ring of earlier rows, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            line_mem[wr_addr] <= pix_reg;
        end
        if (mem_rd)
        begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    // ---------------- lanes and output merge ----------------
    logic [N_LANES-1:0][7:0] lane_res;

    for (genvar l = 0; l < N_LANES; l++)
    begin : g_lane
        gblur_lane #(
            .MAX_KERNEL (MAX_KERNEL),
            .TAP_W      (TAP_W),
            .V_W        (V_W),
            .ACC_W      (ACC_W),
            .SAT_SHIFT  (2 * WEIGHT_BITS)
        ) u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .pix_byte (col_pix[8*l +: 8]),
            .v_tap    (v_tap),
            .h_tap    (h_tap),
            .h_idx    (h_idx),
            .result   (lane_res[l])
        );
    end

    gblur_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .lane_res  (lane_res),
        .last      (last_s),
        .fend      (last_s && fend),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .blur0     (blur0),
        .blur1     (blur1),
        .blur2     (blur2),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

endmodule

### hw/rtl/gblur_check.sv
// Port-level checker for the RGB Gaussian blur block, bound to the top.
// Depends on gblur_pkg and gaussian_blur_rgb_replicate.
module gblur_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [gblur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [gblur_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                             pix_valid,
    input logic                             pix_stall,
    input logic                             mode,
    input logic [7:0]                       chan0,
    input logic [7:0]                       chan1,
    input logic [7:0]                       chan2,
    input logic                             res_valid,
    input logic                             res_stall,
    input logic [7:0]                       blur0,
    input logic [7:0]                       blur1,
    input logic [7:0]                       blur2,
    input logic                             run_last,
    input logic                             frame_end
);
    import gblur_pkg::*;

    // a stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(blur0) && $stable(blur1)
                                   && $stable(blur2) && $stable(run_last))
        else $error("stalled result changed");

    // the frame's final pixel closes its item's run
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_end |-> run_last)
        else $error("frame_end without run_last");

    // a pixel item always starts work
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && !mode |=> pix_stall)
        else $error("pixel item did not start work");

    // no new item while a result is pending
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pix_stall)
        else $error("input open while result pending");

endmodule

bind gaussian_blur_rgb_replicate gblur_check u_check (.*);
